@@ hw/rtl/bitmap_page_allocator_macros.svh @@
// assertion macros for the page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("bitmap_page_allocator: assertion failed");
`define BPA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("bitmap_page_allocator: assertion failed");
`else
`define BPA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define BPA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

@@ hw/rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MAX_PAGES_DEF  = 131072;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 18;
    localparam int TOTAL_W    = 18;
    localparam int FFP_W      = 21;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 1;

    localparam int PAGE_TOTAL_RST = 3840;
    localparam int FIRST_FREE_RST = 256;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_INIT  = 2'd2;

    localparam status_t STS_OK      = 2'd0;
    localparam status_t STS_OOM     = 2'd1;
    localparam status_t STS_IGNORED = 2'd2;

    localparam cfg_idx_t CFG_PAGE_TOTAL = 1'd0;
    localparam cfg_idx_t CFG_FIRST_FREE = 1'd1;

    typedef struct packed {
        logic accept;
        logic load;
        logic sweep;
        logic scan;
        logic free_chk;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/bpa_req_if.sv @@
`timescale 1ns / 1ps

interface bpa_req_if;
    logic                            valid;
    logic                            ready;
    bpa_pkg::cmd_t                   cmd;
    logic [bpa_pkg::ADDR_W-1:0]      free_addr;

    modport source (output valid, cmd, free_addr, input ready);
    modport sink (input valid, cmd, free_addr, output ready);
endinterface

@@ hw/rtl/bpa_rsp_if.sv @@
`timescale 1ns / 1ps

interface bpa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bpa_pkg::ADDR_W-1:0]      page_addr;
    bpa_pkg::status_t                status;
    logic [bpa_pkg::COUNT_W-1:0]     used_count;
    logic [bpa_pkg::COUNT_W-1:0]     free_count;

    modport source (output valid, page_addr, status, used_count, free_count, input ready);
    modport sink (input valid, page_addr, status, used_count, free_count, output ready);
endinterface

@@ hw/rtl/bpa_ctrl.sv @@
`timescale 1ns / 1ps

module bpa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  bpa_pkg::cmd_t req_cmd,
    input  bpa_pkg::sts_t sts,
    output logic          req_ready,
    output bpa_pkg::ctl_t ctl
);

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FREE  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       report_reg;
    logic       report_next;

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        req_ready   = 1'b0;
        ctl         = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                ctl.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    unique case (req_cmd)
                        bpa_pkg::CMD_ALLOC: state_next = ST_SCAN;
                        bpa_pkg::CMD_FREE:  state_next = ST_FREE;
                        bpa_pkg::CMD_INIT:  state_next = ST_LOAD;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                ctl.load    = 1'b1;
                report_next = 1'b1;
                state_next  = ST_SWEEP;
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE:
            begin
                ctl.free_chk = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // power-up sweep rebuilds the map without a result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

endmodule

@@ hw/rtl/bpa_datapath.sv @@
`timescale 1ns / 1ps

module bpa_datapath
#(
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  bpa_pkg::cfg_idx_t                 cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bpa_pkg::cmd_t                     req_cmd,
    input  logic [bpa_pkg::ADDR_W-1:0]        req_free_addr,
    input  bpa_pkg::ctl_t                     ctl,
    output bpa_pkg::sts_t                     sts,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [bpa_pkg::ADDR_W-1:0]        rsp_page_addr,
    output bpa_pkg::status_t                  rsp_status,
    output logic [bpa_pkg::COUNT_W-1:0]       rsp_used_count,
    output logic [bpa_pkg::COUNT_W-1:0]       rsp_free_count
);

    localparam int WORD_BITS  = bpa_pkg::WORD_BITS;
    localparam int WORD_SHIFT = bpa_pkg::WORD_SHIFT;
    localparam int ADDR_W     = bpa_pkg::ADDR_W;
    localparam int COUNT_W    = bpa_pkg::COUNT_W;
    localparam int TOTAL_W    = bpa_pkg::TOTAL_W;
    localparam int FFP_W      = bpa_pkg::FFP_W;

    localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int WCNT_W     = $clog2(MAP_WORDS + 1);
    localparam int PIDX_W     = WADDR_W + WORD_SHIFT;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int P_W        = ADDR_W - PAGE_SHIFT;
    localparam int MPG_W      = $clog2(MAX_PAGES + 1);
    localparam int CAP_W      = (TOTAL_W > MPG_W) ? TOTAL_W : MPG_W;
    localparam int HW         = (FFP_W > WCNT_W) ? FFP_W : WCNT_W;
    localparam int CW         = ((FFP_W - WORD_SHIFT) > WADDR_W) ? (FFP_W - WORD_SHIFT)
                                                                 : WADDR_W;
    localparam int RW         = (P_W > TOTAL_W) ? P_W : TOTAL_W;
    localparam int AW         = ((PIDX_W + PAGE_SHIFT) > ADDR_W) ? (PIDX_W + PAGE_SHIFT)
                                                                 : ADDR_W;

    localparam int EFF_RST  = (bpa_pkg::PAGE_TOTAL_RST < MAX_PAGES) ? bpa_pkg::PAGE_TOTAL_RST
                                                                    : MAX_PAGES;
    localparam int USED_RST = (bpa_pkg::FIRST_FREE_RST < EFF_RST) ? bpa_pkg::FIRST_FREE_RST
                                                                  : EFF_RST;
    localparam int WEND_RST = (EFF_RST + WORD_BITS - 1) / WORD_BITS;
    localparam int FW_RST   = bpa_pkg::FIRST_FREE_RST / WORD_BITS;
    localparam int HINT_RST = (FW_RST < WEND_RST) ? FW_RST : WEND_RST;

    // configuration registers
    logic [TOTAL_W-1:0]   page_total_reg;
    logic [FFP_W-1:0]     first_free_reg;

    // map state latched at init
    logic [TOTAL_W-1:0]   eff_reg, eff_next;
    logic [FFP_W-1:0]     ffp_reg, ffp_next;
    logic [WCNT_W-1:0]    words_end_reg, words_end_next;
    logic [WCNT_W-1:0]    hint_reg, hint_next;
    logic [COUNT_W-1:0]   used_reg, used_next;

    logic [WADDR_W-1:0]   sweep_ptr_reg, sweep_ptr_next;
    logic [WCNT_W-1:0]    scan_ptr_reg, scan_ptr_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [WADDR_W-1:0]   rd_word_reg, rd_word_next;
    logic [WADDR_W-1:0]   free_word_reg, free_word_next;
    logic [WORD_SHIFT-1:0] free_bit_reg, free_bit_next;
    logic                 free_ok_reg, free_ok_next;
    logic [ADDR_W-1:0]    page_addr_reg, page_addr_next;
    bpa_pkg::status_t     status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_addr_reg;
    bpa_pkg::status_t     out_status_reg;
    logic [COUNT_W-1:0]   out_used_reg;
    logic [COUNT_W-1:0]   out_free_reg;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [TOTAL_W-1:0]   eff_cfg;
    logic [COUNT_W-1:0]   used_cfg;
    logic [TOTAL_W:0]     eff_round;
    logic [WCNT_W-1:0]    wend_cfg;
    logic [WCNT_W-1:0]    hint_cfg;

    logic [CW-1:0]        sw_word;
    logic [CW-1:0]        sw_ffp_word;
    logic [CW-1:0]        sw_eff_word;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;

    logic [P_W-1:0]       req_page;
    logic [PIDX_W-1:0]    req_pidx;
    logic                 req_in_range;

    logic                 scan_issue;
    logic                 scan_hit;
    logic [WORD_SHIFT-1:0] zero_idx;
    logic [AW-1:0]        hit_addr_full;
    logic                 free_used;
    logic                 free_clear;
    logic [WCNT_W-1:0]    free_word_ext;

    // parameters for an init from the registers
    always_comb
    begin
        eff_cfg   = (CAP_W'(page_total_reg) < CAP_W'(MAX_PAGES)) ? page_total_reg
                                                                : TOTAL_W'(MAX_PAGES);
        used_cfg  = (first_free_reg < FFP_W'(eff_cfg)) ? COUNT_W'(first_free_reg) : eff_cfg;
        eff_round = {1'b0, eff_cfg} + (TOTAL_W + 1)'(WORD_BITS - 1);
        wend_cfg  = WCNT_W'(eff_round >> WORD_SHIFT);
        hint_cfg  = (HW'(first_free_reg >> WORD_SHIFT) < HW'(wend_cfg))
                    ? WCNT_W'(first_free_reg >> WORD_SHIFT) : wend_cfg;
    end

    // init word: reserved pages below ffp, unmanaged pages from eff up
    always_comb
    begin
        sw_word     = CW'(sweep_ptr_reg);
        sw_ffp_word = CW'(ffp_reg >> WORD_SHIFT);
        sw_eff_word = CW'(eff_reg >> WORD_SHIFT);
        if (sw_word < sw_ffp_word)
        begin
            lo_mask = '1;
        end
        else if (sw_word == sw_ffp_word)
        begin
            lo_mask = (WORD_BITS'(1) << ffp_reg[WORD_SHIFT-1:0]) - WORD_BITS'(1);
        end
        else
        begin
            lo_mask = '0;
        end
        if (sw_word > sw_eff_word)
        begin
            hi_mask = '1;
        end
        else if (sw_word == sw_eff_word)
        begin
            hi_mask = ~((WORD_BITS'(1) << eff_reg[WORD_SHIFT-1:0]) - WORD_BITS'(1));
        end
        else
        begin
            hi_mask = '0;
        end
    end

    always_comb
    begin
        req_page     = req_free_addr[ADDR_W-1:PAGE_SHIFT];
        req_pidx     = PIDX_W'(req_page);
        req_in_range = RW'(req_page) < RW'(eff_reg);
    end

    // lowest clear bit of the word under test
    always_comb
    begin
        zero_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_data_reg[i])
            begin
                zero_idx = WORD_SHIFT'(i);
            end
        end
    end

    always_comb
    begin
        scan_issue    = ctl.scan && (scan_ptr_reg < words_end_reg);
        scan_hit      = ctl.scan && rd_pend_reg && (rd_data_reg != '1);
        hit_addr_full = AW'({rd_word_reg, zero_idx}) << PAGE_SHIFT;
        free_used     = rd_data_reg[free_bit_reg];
        free_clear    = ctl.free_chk && free_ok_reg && free_used && (used_reg != '0);
        free_word_ext = WCNT_W'(free_word_reg);

        sts.sweep_last = (sweep_ptr_reg == WADDR_W'(MAP_WORDS - 1));
        sts.scan_done  = scan_hit || (ctl.scan && !rd_pend_reg && !scan_issue);
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        eff_next       = eff_reg;
        ffp_next       = ffp_reg;
        words_end_next = words_end_reg;
        hint_next      = hint_reg;
        used_next      = used_reg;
        sweep_ptr_next = sweep_ptr_reg;
        scan_ptr_next  = scan_ptr_reg;
        rd_pend_next   = scan_issue;
        rd_word_next   = rd_word_reg;
        free_word_next = free_word_reg;
        free_bit_next  = free_bit_reg;
        free_ok_next   = free_ok_reg;
        page_addr_next = page_addr_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;

        rd_en   = 1'b0;
        rd_addr = scan_ptr_reg[WADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = sweep_ptr_reg;
        wr_data = lo_mask | hi_mask;

        if (ctl.accept)
        begin
            page_addr_next = '0;
            status_next    = bpa_pkg::STS_OK;
            unique case (req_cmd)
                bpa_pkg::CMD_ALLOC:
                begin
                    scan_ptr_next = hint_reg;
                    status_next   = bpa_pkg::STS_OOM;
                end
                bpa_pkg::CMD_FREE:
                begin
                    free_word_next = req_pidx[PIDX_W-1:WORD_SHIFT];
                    free_bit_next  = req_pidx[WORD_SHIFT-1:0];
                    free_ok_next   = req_in_range;
                    rd_en          = 1'b1;
                    rd_addr        = req_pidx[PIDX_W-1:WORD_SHIFT];
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.load)
        begin
            eff_next       = eff_cfg;
            ffp_next       = first_free_reg;
            used_next      = used_cfg;
            words_end_next = wend_cfg;
            hint_next      = hint_cfg;
            sweep_ptr_next = '0;
        end

        if (ctl.sweep)
        begin
            wr_en          = 1'b1;
            sweep_ptr_next = sweep_ptr_reg + 1'b1;
        end

        // reads go out one a cycle, each word is tested in the cycle after its read
        if (scan_issue)
        begin
            rd_en         = 1'b1;
            rd_addr       = scan_ptr_reg[WADDR_W-1:0];
            rd_word_next  = scan_ptr_reg[WADDR_W-1:0];
            scan_ptr_next = scan_ptr_reg + 1'b1;
        end

        if (scan_hit)
        begin
            wr_en          = 1'b1;
            wr_addr        = rd_word_reg;
            wr_data        = rd_data_reg | (WORD_BITS'(1) << zero_idx);
            used_next      = used_reg + 1'b1;
            page_addr_next = hit_addr_full[ADDR_W-1:0];
            status_next    = bpa_pkg::STS_OK;
            hint_next      = WCNT_W'(rd_word_reg);
        end

        if (ctl.free_chk)
        begin
            if (free_clear)
            begin
                wr_en     = 1'b1;
                wr_addr   = free_word_reg;
                wr_data   = rd_data_reg & ~(WORD_BITS'(1) << free_bit_reg);
                used_next = used_reg - 1'b1;
                hint_next = (free_word_ext < hint_reg) ? free_word_ext : hint_reg;
            end
            else
            begin
                status_next = bpa_pkg::STS_IGNORED;
            end
        end

        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_total_reg <= TOTAL_W'(bpa_pkg::PAGE_TOTAL_RST);
            first_free_reg <= FFP_W'(bpa_pkg::FIRST_FREE_RST);
            eff_reg        <= TOTAL_W'(EFF_RST);
            ffp_reg        <= FFP_W'(bpa_pkg::FIRST_FREE_RST);
            words_end_reg  <= WCNT_W'(WEND_RST);
            hint_reg       <= WCNT_W'(HINT_RST);
            used_reg       <= COUNT_W'(USED_RST);
            sweep_ptr_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bpa_pkg::CFG_PAGE_TOTAL: page_total_reg <= cfg_data[TOTAL_W-1:0];
                    bpa_pkg::CFG_FIRST_FREE: first_free_reg <= cfg_data[FFP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            eff_reg       <= eff_next;
            ffp_reg       <= ffp_next;
            words_end_reg <= words_end_next;
            hint_reg      <= hint_next;
            used_reg      <= used_next;
            sweep_ptr_reg <= sweep_ptr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg  <= scan_ptr_next;
        rd_word_reg   <= rd_word_next;
        free_word_reg <= free_word_next;
        free_bit_reg  <= free_bit_next;
        free_ok_reg   <= free_ok_next;
        page_addr_reg <= page_addr_next;
        status_reg    <= status_next;
        if (ctl.finish)
        begin
            out_addr_reg   <= page_addr_reg;
            out_status_reg <= status_reg;
            out_used_reg   <= used_reg;
            out_free_reg   <= (eff_reg >= used_reg) ? (eff_reg - used_reg) : '0;
        end
    end

    // used-bit map, one word per 32 pages
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_page_addr  = out_addr_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_used_count = out_used_reg;
    assign rsp_free_count = out_free_reg;

endmodule

@@ hw/rtl/bitmap_page_allocator.sv @@
// First-fit page allocator holding one used bit per page in a map of 32-bit words
// (MAX_PAGES / 32 words, 4096 with the defaults) kept in a single-port-read memory.
// After reset, and on every init command, the map is rebuilt by a sweep that writes
// one word a cycle through the whole map, and no command is taken until the sweep ends;
// the result word of an init follows its sweep. An allocate reads the map one word a
// cycle from the lowest word that may still hold a free page, until a free page turns
// up or the managed words run out. One command is in flight at a time, and the next
// is accepted while the previous result word still waits on the output register.
// Register writes take effect only at the next init command.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator
#(
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  bpa_pkg::cfg_idx_t              cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
    bpa_req_if.sink                        req,
    bpa_rsp_if.source                      rsp
);

    bpa_pkg::ctl_t ctl;
    bpa_pkg::sts_t sts;
    logic          oom_word;
    logic          oom_clear;

    bpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .sts       (sts),
        .req_ready (req.ready),
        .ctl       (ctl)
    );

    bpa_datapath
    #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_cmd        (req.cmd),
        .req_free_addr  (req.free_addr),
        .ctl            (ctl),
        .sts            (sts),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_page_addr  (rsp.page_addr),
        .rsp_status     (rsp.status),
        .rsp_used_count (rsp.used_count),
        .rsp_free_count (rsp.free_count)
    );

    assign oom_word  = rsp.valid && rsp.status == bpa_pkg::STS_OOM;
    assign oom_clear = rsp.free_count == '0 && rsp.page_addr == '0;

    // out of memory only when every managed page is used
    `BPA_ASSERT_IMP(a_oom_full, clk, rst_n, oom_word, oom_clear)
    `BPA_ASSERT_IMP(a_finish_slot, clk, rst_n, ctl.finish, !rsp.valid || rsp.ready)
    `BPA_ASSERT_NXT(a_single_cmd, clk, rst_n, req.valid && req.ready, !req.ready)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int MAP_PAGES   = bpa_pkg::MAX_PAGES_DEF;
    localparam int PAGE_BYTES  = bpa_pkg::PAGE_BYTES_DEF;
    localparam int ADDR_W      = bpa_pkg::ADDR_W;
    localparam int COUNT_W     = bpa_pkg::COUNT_W;
    localparam int TOTAL_W     = bpa_pkg::TOTAL_W;
    localparam int FFP_W       = bpa_pkg::FFP_W;
    localparam int CFG_DATA_W  = bpa_pkg::CFG_DATA_W;
    localparam bpa_pkg::cmd_t CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_addr;
        bpa_pkg::status_t   status;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } page_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    bpa_pkg::cfg_idx_t     cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bpa_req_if req_if();
    bpa_rsp_if rsp_if();

    bitmap_page_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // predicted allocator state
    bit                 page_used [MAP_PAGES];
    int unsigned        pages_in_use;
    int unsigned        eff_total;
    int unsigned        scan_from;
    logic [TOTAL_W-1:0] reg_page_total;
    logic [FFP_W-1:0]   reg_first_free;

    page_result_t pending_results [$];
    int unsigned  allocated_pages [$];
    page_result_t want;

    int error_count   = 0;
    int words_checked = 0;
    int n_alloc       = 0;
    int n_oom         = 0;
    int n_ignored     = 0;
    int n_init        = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit calm_flow     = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_len(input int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void rebuild_map();
        eff_total = (reg_page_total < MAP_PAGES) ? reg_page_total : MAP_PAGES;
        for (int p = 0; p < MAP_PAGES; p++)
            page_used[p] = !(p >= reg_first_free && p < eff_total);
        pages_in_use = (reg_first_free < eff_total) ? reg_first_free : eff_total;
        scan_from = pages_in_use;
        allocated_pages.delete();
    endfunction

    function automatic page_result_t apply_command(input bpa_pkg::cmd_t c,
                                                   input logic [ADDR_W-1:0] a);
        page_result_t r;
        int unsigned  pg;
        r.page_addr = '0;
        r.status    = bpa_pkg::STS_OK;
        case (c)
            bpa_pkg::CMD_ALLOC:
            begin
                r.status = bpa_pkg::STS_OOM;
                for (pg = scan_from; pg < eff_total; pg++)
                begin
                    if (!page_used[pg])
                    begin
                        page_used[pg] = 1'b1;
                        pages_in_use++;
                        r.page_addr = pg * PAGE_BYTES;
                        r.status    = bpa_pkg::STS_OK;
                        allocated_pages.push_back(pg);
                        scan_from = pg + 1;
                        break;
                    end
                end
            end
            bpa_pkg::CMD_FREE:
            begin
                pg = a / PAGE_BYTES;
                if (pg < eff_total && page_used[pg] && pages_in_use > 0)
                begin
                    page_used[pg] = 1'b0;
                    pages_in_use--;
                    if (pg < scan_from)
                        scan_from = pg;
                end
                else
                begin
                    r.status = bpa_pkg::STS_IGNORED;
                end
            end
            bpa_pkg::CMD_INIT:
            begin
                rebuild_map();
                n_init++;
            end
            default:
            begin
            end
        endcase
        r.used_count = COUNT_W'(pages_in_use);
        r.free_count = (eff_total >= pages_in_use) ? COUNT_W'(eff_total - pages_in_use) : '0;
        if (c == bpa_pkg::CMD_ALLOC && r.status == bpa_pkg::STS_OK)
            n_alloc++;
        if (r.status == bpa_pkg::STS_OOM)
            n_oom++;
        if (r.status == bpa_pkg::STS_IGNORED)
            n_ignored++;
        return r;
    endfunction

    task automatic send_cmd(input bpa_pkg::cmd_t c, input logic [ADDR_W-1:0] a);
        int gap;
        gap = pick_len(calm_flow ? 0 : 35);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= c;
        req_if.free_addr <= a;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.push_back(apply_command(c, a));
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input bpa_pkg::cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == bpa_pkg::CFG_PAGE_TOTAL)
            reg_page_total = data[TOTAL_W-1:0];
        else
            reg_first_free = data[FFP_W-1:0];
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] total_word,
                             input logic [CFG_DATA_W-1:0] first_word);
        write_reg(bpa_pkg::CFG_PAGE_TOTAL, total_word);
        write_reg(bpa_pkg::CFG_FIRST_FREE, first_word);
        send_cmd(bpa_pkg::CMD_INIT, $urandom);
    endtask

    task automatic test_reset_state();
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_FREE, 32'h0010_0123);
        // reserved page zero can be freed and handed out again
        send_cmd(bpa_pkg::CMD_FREE, 32'h0000_0000);
        send_cmd(bpa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        send_cmd(bpa_pkg::CMD_FREE, 32'h00F0_0000);
        send_cmd(bpa_pkg::CMD_FREE, 32'hFFFF_FFFF);
        send_cmd(CMD_UNUSED, 32'hA5A5_5A5A);
    endtask

    task automatic test_small_map();
        write_reg(bpa_pkg::CFG_PAGE_TOTAL, 21'd4);
        write_reg(bpa_pkg::CFG_FIRST_FREE, 21'd2);
        // staged registers not yet in force
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_INIT, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_FREE, 32'h0000_2000);
        send_cmd(bpa_pkg::CMD_FREE, 32'h0000_2FFF);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
    endtask

    task automatic test_register_extremes();
        configure(21'd0, 21'd1048576);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        // total saturates at the map size, upper data bits dropped
        configure(21'h1F_FFFF, 21'd131070);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        configure(21'd131072, 21'h1F_FFFF);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_FREE, 32'hFFFF_F000);
        configure(21'd1, 21'd0);
        send_cmd(bpa_pkg::CMD_ALLOC, '0);
        send_cmd(bpa_pkg::CMD_FREE, 32'h0000_0FFF);
    endtask

    task automatic random_item();
        int          r;
        int          k;
        int unsigned pg;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            send_cmd(bpa_pkg::CMD_ALLOC, $urandom);
        end
        else if (r < 80 && allocated_pages.size() > 0)
        begin
            k  = $urandom_range(0, allocated_pages.size() - 1);
            pg = allocated_pages[k];
            allocated_pages.delete(k);
            send_cmd(bpa_pkg::CMD_FREE, pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
        end
        else if (r < 88)
        begin
            pg = $urandom_range(0, eff_total);
            send_cmd(bpa_pkg::CMD_FREE, pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
        end
        else if (r < 95)
        begin
            send_cmd(bpa_pkg::CMD_FREE, $urandom);
        end
        else if (r < 98)
        begin
            send_cmd(bpa_pkg::CMD_INIT, $urandom);
        end
        else
        begin
            send_cmd(CMD_UNUSED, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        logic [TOTAL_W-1:0] total;
        logic [FFP_W-1:0]   first;
        logic [2:0]         spare;
        for (int ph = 0; ph < 5; ph++)
        begin
            spare = 3'($urandom);
            case (ph)
                0, 2:
                begin
                    total = TOTAL_W'($urandom_range(0, 40));
                    first = FFP_W'($urandom_range(0, total + 3));
                end
                1:
                begin
                    total = TOTAL_W'($urandom_range(3000, 3840));
                    first = FFP_W'($urandom_range(0, 300));
                end
                3:
                begin
                    total = TOTAL_W'($urandom_range(131072, 262143));
                    first = FFP_W'($urandom_range(131000, 131072));
                end
                default:
                begin
                    total = TOTAL_W'($urandom);
                    first = FFP_W'($urandom);
                end
            endcase
            calm_flow = (ph == 1);
            configure({spare, total}, first);
            repeat (21) random_item();
        end
        calm_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            stall_left   <= calm_flow ? 0 : pick_len(25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                words_checked++;
                if (rsp_if.page_addr !== want.page_addr)
                begin
                    $error("page_addr: expected %h, got %h", want.page_addr, rsp_if.page_addr);
                    error_count++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.used_count !== want.used_count)
                begin
                    $error("used_count: expected %0d, got %0d", want.used_count,
                           rsp_if.used_count);
                    error_count++;
                end
                if (rsp_if.free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, got %0d", want.free_count,
                           rsp_if.free_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        req_if.valid     <= 1'b0;
        req_if.cmd       <= bpa_pkg::CMD_ALLOC;
        req_if.free_addr <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= bpa_pkg::CFG_PAGE_TOTAL;
        cfg_data         <= '0;
        reg_page_total   = TOTAL_W'(bpa_pkg::PAGE_TOTAL_RST);
        reg_first_free   = FFP_W'(bpa_pkg::FIRST_FREE_RST);
        rebuild_map();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_small_map();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("checked %0d result words across %0d map rebuilds", words_checked, n_init);
        $display("%0d pages handed out, %0d out-of-memory answers, %0d ignored frees",
                 n_alloc, n_oom, n_ignored);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
